/* design/ffra_pkg.sv */
// Package for the first-fit range allocator: shared constants, types and codes.
// No dependencies.
`default_nettype none
package ffra_pkg;
  localparam int unsigned MaxRangesDef = 16;
  localparam int unsigned MaxSlotsDef  = 1024;
  localparam int unsigned AddrW   = 48;
  localparam int unsigned StrideW = 13;
  localparam int unsigned CfgAw   = 5;

  localparam logic [CfgAw-1:0] RegPageSlots = 5'h00;
  localparam logic [CfgAw-1:0] RegBaseAddr  = 5'h08;
  localparam logic [CfgAw-1:0] RegStride    = 5'h10;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StFail = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  localparam logic FuncAlloc   = 1'b0;
  localparam logic FuncRelease = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_MUL, S_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic start;      // latch request, clear scan index
    logic scan_step;  // evaluate one entry and advance
    logic decide;     // apply split/merge at the found position
    logic shift_step; // move one entry during insert or remove
    logic mul;        // compute granted address
    logic out_load;   // present result
  } ffra_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic need_shift;
    logic shift_done;
    logic need_mul;
  } ffra_sts_t;
endpackage
`default_nettype wire

/* design/ffra_ctrl.sv */
// Controller state machine of the first-fit range allocator.
// Depends on ffra_pkg.
`default_nettype none
module ffra_ctrl import ffra_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire        out_free_i,
  input  ffra_sts_t  sts_i,
  output ffra_cmd_t  cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_SCAN;
      S_SCAN:  if (sts_i.scan_done) begin
                 if (sts_i.need_shift) state_d = S_SHIFT;
                 else if (sts_i.need_mul) state_d = S_MUL;
                 else state_d = S_DONE;
               end
      S_SHIFT: if (sts_i.shift_done) begin
                 if (sts_i.need_mul) state_d = S_MUL;
                 else state_d = S_DONE;
               end
      S_MUL:   state_d = S_DONE;
      S_DONE:  if (out_free_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.start = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.scan_step = !sts_i.scan_done;
        cmd_o.decide = sts_i.scan_done;
      end
      S_SHIFT: cmd_o.shift_step = !sts_i.shift_done;
      S_MUL:   cmd_o.mul = 1'b1;
      S_DONE:  cmd_o.out_load = out_free_i;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == S_SCAN) else $error("start did not scan");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> state_q == S_IDLE) else $error("load did not finish");
`endif
endmodule
`default_nettype wire

/* design/ffra_dp.sv */
// Datapath of the first-fit range allocator: free-range list, scan, shift,
// address multiply and result register. Depends on ffra_pkg.
`default_nettype none
module ffra_dp import ffra_pkg::*; #(
  parameter int unsigned MaxRanges = MaxRangesDef,
  parameter int unsigned MaxSlots  = MaxSlotsDef
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  ffra_cmd_t        cmd_i,
  output ffra_sts_t        sts_o,
  input  wire              req_func_i,
  input  wire [10:0]       req_count_i,
  input  wire [9:0]        req_offset_i,
  input  wire              page_wr_i,
  input  wire [10:0]       page_val_i,
  input  wire [AddrW-1:0]  base_i,
  input  wire [StrideW-1:0] stride_i,
  output logic [10:0]      page_o,
  output logic             out_valid_o,
  input  wire              out_taken_i,
  output logic [1:0]       status_o,
  output logic [9:0]       goff_o,
  output logic [AddrW-1:0] gaddr_o,
  output logic [10:0]      free_o
);
  localparam int unsigned IdxW = $clog2(MaxRanges);
  localparam int unsigned CntW = $clog2(MaxRanges + 1);

  logic [9:0]  start_q [MaxRanges];
  logic [10:0] len_q   [MaxRanges];
  logic [CntW-1:0] cnt_q;
  logic [10:0] free_q, page_q;
  logic        func_q;
  logic [10:0] rcnt_q;
  logic [9:0]  roff_q;
  logic [CntW-1:0] idx_q;     // scan index, also shift index
  logic [1:0]  st_q;
  logic [9:0]  goff_q;
  logic [AddrW-1:0] gaddr_q;
  logic        grant_q;  // allocate found a range; address still to compute
  logic        ins_q;  // shift direction: 1 insert (up), 0 remove (down)
  logic [CntW-1:0] pos_q;     // found position
  logic [CntW-1:0] send_q;    // shift end

  // Result word held for the output side while the next request runs.
  logic [1:0]       res_st_q;
  logic [9:0]       res_goff_q;
  logic [AddrW-1:0] res_gaddr_q;
  logic [10:0]      res_free_q;

  // Current entry and its left neighbor.
  logic [IdxW-1:0] ix, ixm;
  logic [9:0]  cur_s, prv_s;
  logic [10:0] cur_l, prv_l;
  logic [11:0] prv_end, rel_end;
  logic scan_at_end, hit;
  assign ix  = idx_q[IdxW-1:0];
  assign ixm = ix - 1'b1;
  assign cur_s = start_q[ix];
  assign cur_l = len_q[ix];
  assign prv_s = start_q[ixm];
  assign prv_l = len_q[ixm];
  assign prv_end = {2'b0, prv_s} + {1'b0, prv_l};
  assign rel_end = {2'b0, roff_q} + {1'b0, rcnt_q};
  assign scan_at_end = (idx_q == cnt_q);
  // Allocate: first entry long enough. Release: first entry past the offset.
  assign hit = !scan_at_end && (func_q == FuncAlloc ? (rcnt_q <= cur_l)
                                                    : (roff_q < cur_s));

  // Scan finishes at a hit, at the list end, or at once on trivial requests.
  logic trivial;
  assign trivial = (rcnt_q == '0) ||
                   (func_q == FuncRelease && rel_end > {1'b0, page_q});
  assign sts_o.scan_done = trivial || hit || scan_at_end;

  // Decision at the insertion point (release) or found entry (allocate).
  logic has_l, has_r, ovl, mrg_l, mrg_r;
  assign has_l = (idx_q != '0);
  assign has_r = !scan_at_end;
  assign ovl   = (has_l && prv_end > {2'b0, roff_q}) ||
                 (has_r && rel_end > {2'b0, cur_s});
  assign mrg_l = has_l && prv_end == {2'b0, roff_q};
  assign mrg_r = has_r && rel_end == {2'b0, cur_s};

  logic rel_ok, rel_full, alloc_ok, exact;
  assign rel_ok   = func_q == FuncRelease && !trivial && !ovl;
  assign rel_full = rel_ok && !mrg_l && !mrg_r && cnt_q == CntW'(MaxRanges);
  assign alloc_ok = func_q == FuncAlloc && rcnt_q != '0 && hit;
  assign exact    = alloc_ok && rcnt_q == cur_l;
  assign sts_o.need_shift = (exact && (idx_q + 1'b1 != cnt_q)) ||
    (rel_ok && !rel_full && ((mrg_l && mrg_r && idx_q + 1'b1 != cnt_q) ||
                             (!mrg_l && !mrg_r && !scan_at_end)));
  // While a removal shift runs the scan signals no longer hold, so a grant
  // is remembered for the multiply that follows the shift.
  assign sts_o.need_mul = alloc_ok || grant_q;

  // Shift: insert moves entries up from the end to pos; remove moves down
  // until every entry below the new count has been filled.
  assign sts_o.shift_done = ins_q ? (idx_q == pos_q) : (idx_q >= send_q);

  logic [IdxW-1:0] ip1;
  assign ip1 = IdxW'(idx_q + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CntW'(1);
      page_q <= 11'(MaxSlots);
      free_q <= 11'(MaxSlots);
      for (int i = 0; i < MaxRanges; i++) begin
        start_q[i] <= '0;
        len_q[i] <= (i == 0) ? 11'(MaxSlots) : '0;
      end
      out_valid_o <= 1'b0;
      idx_q <= '0;
      grant_q <= 1'b0;
      res_st_q <= '0;
      res_goff_q <= '0;
      res_gaddr_q <= '0;
      res_free_q <= '0;
    end else begin
      if (cmd_i.out_load) out_valid_o <= 1'b1;
      else if (out_taken_i) out_valid_o <= 1'b0;
      if (page_wr_i) begin
        page_q <= page_val_i;
        free_q <= page_val_i;
        cnt_q <= CntW'(1);
        for (int i = 0; i < MaxRanges; i++) begin
          start_q[i] <= '0;
          len_q[i] <= (i == 0) ? page_val_i : '0;
        end
      end
      if (cmd_i.start) begin
        func_q <= req_func_i;
        rcnt_q <= req_count_i;
        roff_q <= req_offset_i;
        idx_q <= '0;
        goff_q <= '0;
        gaddr_q <= '0;
        grant_q <= 1'b0;
      end
      if (cmd_i.scan_step) idx_q <= idx_q + 1'b1;
      if (cmd_i.decide) begin
        pos_q <= idx_q;
        if (func_q == FuncAlloc) begin
          if (rcnt_q == '0) st_q <= StOk;
          else if (!alloc_ok) st_q <= StFail;
          else begin
            st_q <= StOk;
            grant_q <= 1'b1;
            goff_q <= cur_s;
            free_q <= free_q - rcnt_q;
            if (!exact) begin
              start_q[ix] <= cur_s + rcnt_q[9:0];
              len_q[ix] <= cur_l - rcnt_q;
            end else begin
              cnt_q <= cnt_q - 1'b1;
              start_q[ix] <= '0;
              len_q[ix] <= '0;
              ins_q <= 1'b0;
              send_q <= cnt_q - 1'b1;
            end
          end
        end else if (rcnt_q == '0) begin
          st_q <= StOk;
        end else if (trivial || ovl) begin
          st_q <= StFail;
        end else if (rel_full) begin
          st_q <= StFull;
        end else begin
          st_q <= StOk;
          free_q <= free_q + rcnt_q;
          if (mrg_l && mrg_r) begin
            len_q[ixm] <= prv_l + rcnt_q + cur_l;
            start_q[ix] <= '0;
            len_q[ix] <= '0;
            cnt_q <= cnt_q - 1'b1;
            ins_q <= 1'b0;
            send_q <= cnt_q - 1'b1;
          end else if (mrg_l) begin
            len_q[ixm] <= prv_l + rcnt_q;
          end else if (mrg_r) begin
            start_q[ix] <= roff_q;
            len_q[ix] <= cur_l + rcnt_q;
          end else begin
            // New entry at the insertion point; later ones move up.
            cnt_q <= cnt_q + 1'b1;
            ins_q <= 1'b1;
            if (scan_at_end) begin
              start_q[ix] <= roff_q;
              len_q[ix] <= rcnt_q;
            end else begin
              idx_q <= cnt_q;
            end
          end
        end
      end
      if (cmd_i.shift_step) begin
        if (ins_q) begin
          if (idx_q == pos_q + 1'b1) begin
            start_q[ix] <= start_q[ixm];
            len_q[ix] <= len_q[ixm];
            start_q[ixm] <= roff_q;
            len_q[ixm] <= rcnt_q;
          end else begin
            start_q[ix] <= start_q[ixm];
            len_q[ix] <= len_q[ixm];
          end
          idx_q <= idx_q - 1'b1;
        end else begin
          start_q[ix] <= start_q[ip1];
          len_q[ix] <= len_q[ip1];
          start_q[ip1] <= '0;
          len_q[ip1] <= '0;
          idx_q <= idx_q + 1'b1;
        end
      end
      if (cmd_i.mul) begin
        gaddr_q <= base_i + AddrW'(goff_q * stride_i);
      end
      if (cmd_i.out_load) begin
        res_st_q <= st_q;
        res_goff_q <= goff_q;
        res_gaddr_q <= gaddr_q;
        res_free_q <= free_q;
      end
    end
  end

  assign status_o = res_st_q;
  assign goff_o   = res_goff_q;
  assign gaddr_o  = res_gaddr_q;
  assign free_o   = res_free_q;
  assign page_o   = page_q;

`ifndef NO_ASSERTIONS
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxRanges)) else $error("range count overflow");
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= page_q) else $error("free total above page size");
  a_fail_noaddr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> gaddr_o == '0 && goff_o == '0)
    else $error("failed request carries a grant");
`endif
endmodule
`default_nettype wire

/* design/first_fit_range_allocator.sv */
// Top level of the first-fit range allocator: APB register file, controller
// and datapath. Depends on ffra_pkg, ffra_ctrl and ffra_dp.
//
// Channel   Dir  Fields (tdata/tuser, low bit first)
// s_axis    in   tdata: slot_count[10:0], slot_offset[20:11]; tuser: func
// m_axis    out  tdata: status[1:0], granted_offset[11:2],
//                granted_address[59:12], free_slots[70:60]
// apb       in   page_slots @0x00, base_address @0x08, slot_stride @0x10
//
// A request takes one scan step per free range entry visited, then a shift
// step for each entry moved when the list grows or shrinks in the middle, and
// an address multiply step on a grant.
// Reset restores one free range over the whole page; a page_slots write does
// the same at once. The result word sits in its own register, so one more
// request can run while it waits; that request then holds in its last cycle
// until the waiting word is taken.
`default_nettype none
module first_fit_range_allocator import ffra_pkg::*; #(
  parameter int unsigned MaxRanges = MaxRangesDef,
  parameter int unsigned MaxSlots  = MaxSlotsDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [23:0]  s_axis_tdata,  // slot_count, slot_offset, zero fill
  input  wire         s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [71:0] m_axis_tdata,  // status, granted_offset, granted_address,
                                     // free_slots, zero fill
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire [CfgAw-1:0] paddr,
  input  wire [63:0]  pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  logic [AddrW-1:0]   base_q;
  logic [StrideW-1:0] stride_q;
  logic [10:0] page;
  logic wr, page_wr;
  logic [10:0] page_clamped;
  ffra_cmd_t cmd;
  ffra_sts_t sts;
  logic [1:0]  st;
  logic [9:0]  goff;
  logic [AddrW-1:0] gaddr;
  logic [10:0] free;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign page_wr = wr && paddr == RegPageSlots;
  // Page size is clamped into 1..MaxSlots on write.
  always_comb begin
    priority if (pwdata[10:0] == '0) page_clamped = 11'd1;
    else if ({1'b0, pwdata[10:0]} > 12'(MaxSlots)) page_clamped = 11'(MaxSlots);
    else page_clamped = pwdata[10:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      stride_q <= StrideW'(32);
    end else begin
      if (wr && paddr == RegBaseAddr) base_q <= pwdata[AddrW-1:0];
      if (wr && paddr == RegStride) stride_q <= pwdata[StrideW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr)
      RegPageSlots: prdata = 64'(page);
      RegBaseAddr:  prdata = 64'(base_q);
      RegStride:    prdata = 64'(stride_q);
      default:      prdata = '0;
    endcase
  end

  ffra_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (!m_axis_tvalid || m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffra_dp #(.MaxRanges(MaxRanges), .MaxSlots(MaxSlots)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_func_i   (s_axis_tuser),
    .req_count_i  (s_axis_tdata[10:0]),
    .req_offset_i (s_axis_tdata[20:11]),
    .page_wr_i    (page_wr),
    .page_val_i   (page_clamped),
    .base_i       (base_q),
    .stride_i     (stride_q),
    .page_o       (page),
    .out_valid_o  (m_axis_tvalid),
    .out_taken_i  (m_axis_tvalid && m_axis_tready),
    .status_o     (st),
    .goff_o       (goff),
    .gaddr_o      (gaddr),
    .free_o       (free)
  );

  assign m_axis_tdata = {1'b0, free, gaddr, goff, st};

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is running");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
`endif
endmodule
`default_nettype wire
